/* sv/degree_minute_integrator_top_defines.svh */
// ----------------------------------------------------------------------------
// degree_minute_integrator_top_defines
// assertion macros shared by the degree-minute integrator rtl
// ----------------------------------------------------------------------------
`ifndef DEGREE_MINUTE_INTEGRATOR_TOP_DEFINES_SVH
`define DEGREE_MINUTE_INTEGRATOR_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DMI_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DMI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/dmi_pkg.sv */
// ----------------------------------------------------------------------------
// dmi_pkg
// types and constants of the degree-minute integrator
// ----------------------------------------------------------------------------
`default_nettype none

package dmi_pkg;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_REMOTE_ENABLE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REMOTE_SETPOINT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ON_THRESHOLD    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_OFF_THRESHOLD   = 2'd3;

  // register reset values
  localparam logic signed [7:0]  REMOTE_SETPOINT_RST = 8'sd50;
  localparam logic signed [15:0] ON_THRESHOLD_RST    = 16'sd15;
  localparam logic signed [15:0] OFF_THRESHOLD_RST   = 16'sd0;

  // input item function codes
  localparam logic FUNC_EVALUATE    = 1'b0;
  localparam logic FUNC_CURVE_WRITE = 1'b1;

  // timing and limits
  localparam int SECONDS_PER_MINUTE = 60;
  localparam int MINUTE_MAX         = 20'hFFFFF;
  localparam int OUTDOOR_LOW_LIMIT  = -20;
  localparam int OUTDOOR_HIGH_LIMIT = 17;

  // next minute boundary in seconds, 60 * minute index
  localparam int BOUNDARY_W = 26;
  localparam logic [BOUNDARY_W-1:0] BOUNDARY_FIRST = BOUNDARY_W'(SECONDS_PER_MINUTE);
  localparam logic [BOUNDARY_W-1:0] BOUNDARY_MAX   =
    BOUNDARY_W'(SECONDS_PER_MINUTE * MINUTE_MAX);

  // word held between curve read and accumulate
  typedef struct packed {
    logic              func;
    logic [19:0]       secs;
    logic signed [7:0] flow;
    logic signed [6:0] outdoor;
    logic              dir;
  } dmi_item_t;

endpackage

`default_nettype wire

/* sv/dmi_ram.sv */
// ----------------------------------------------------------------------------
// dmi_ram
// generic single-write single-read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module dmi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/degree_minute_integrator_top.sv */
// ----------------------------------------------------------------------------
// degree_minute_integrator_top
// heat-pump degree-minute integrator with heating-curve memory
// ----------------------------------------------------------------------------
// Takes one word per cycle unless the receiver stalls, and returns one result
// word per input word. The accept cycle issues the heating-curve memory read
// and loads the stage-one register; stage one does the saturating accumulate
// and threshold compare and loads the output register. Curve writes go to the
// memory at acceptance and return the unchanged accumulator with
// condition_met low. Curve entries must be written before an evaluate word
// selects them by outdoor temperature. Configuration must be written only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "degree_minute_integrator_top_defines.svh"

module degree_minute_integrator_top #(
  parameter int CURVE_DEPTH  = 64,
  parameter int CURVE_OFFSET = 20
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [dmi_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [dmi_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input words
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // elapsed_seconds[19:0], flow_temp[27:20], outdoor_temp[34:28],
  // direction[35], curve_index[41:36], curve_value[49:42], zero[55:50]
  input  wire logic [55:0]                    s_axis_tdata_i,
  // func[0]
  input  wire logic                           s_axis_tuser_i,
  // result words
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // condition_met[0], degree_minutes[32:1], zero[39:33]
  output logic [39:0]                         m_axis_tdata_o
);

  localparam int AW = $clog2(CURVE_DEPTH);
  localparam logic signed [9:0] IDX_MAX = 10'(CURVE_DEPTH - 1);

  // configuration registers
  logic                     remote_en_q;
  logic signed [7:0]        remote_sp_q;
  logic signed [15:0]       on_thr_q;
  logic signed [15:0]       off_thr_q;

  // integrator state
  logic signed [31:0]                 acc_q, acc_d;
  logic [dmi_pkg::BOUNDARY_W-1:0]     boundary_q, boundary_d;

  // pipeline
  logic                     s_fire;
  logic                     advance;
  logic                     out_ready;
  logic                     s1_valid_q;
  dmi_pkg::dmi_item_t       s1_q;
  dmi_pkg::dmi_item_t       in_item;
  logic                     out_valid_q;
  logic                     out_met_q, met_d;
  logic signed [31:0]       out_dm_q;

  // curve memory access
  logic [5:0]               in_cidx;
  logic signed [7:0]        in_cval;
  logic signed [9:0]        ix_raw;
  logic [AW-1:0]            rd_idx;
  logic                     curve_we;
  logic [7:0]               curve_rdata;

  // accumulate path
  logic                     minute_hit;
  logic signed [7:0]        setpoint;
  logic signed [8:0]        diff;
  logic signed [32:0]       acc_ext, diff_ext, sum;
  logic signed [31:0]       sum_sat, acc_clamped, acc_a;
  logic [dmi_pkg::BOUNDARY_W-1:0] boundary_a;
  logic signed [31:0]       on_ext, off_ext;
  logic                     outdoor_ok;

  // input field unpacking
  assign in_item.func    = s_axis_tuser_i;
  assign in_item.secs    = s_axis_tdata_i[19:0];
  assign in_item.flow    = s_axis_tdata_i[27:20];
  assign in_item.outdoor = s_axis_tdata_i[34:28];
  assign in_item.dir     = s_axis_tdata_i[35];
  assign in_cidx         = s_axis_tdata_i[41:36];
  assign in_cval         = s_axis_tdata_i[49:42];

  // handshake and pipeline advance
  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign advance         = s1_valid_q && out_ready;
  assign s_axis_tready_o = !s1_valid_q || out_ready;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remote_en_q <= 1'b0;
      remote_sp_q <= dmi_pkg::REMOTE_SETPOINT_RST;
      on_thr_q    <= dmi_pkg::ON_THRESHOLD_RST;
      off_thr_q   <= dmi_pkg::OFF_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        dmi_pkg::REG_REMOTE_ENABLE:   remote_en_q <= cfg_wdata_i[0];
        dmi_pkg::REG_REMOTE_SETPOINT: remote_sp_q <= cfg_wdata_i[7:0];
        dmi_pkg::REG_ON_THRESHOLD:    on_thr_q    <= cfg_wdata_i;
        dmi_pkg::REG_OFF_THRESHOLD:   off_thr_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // curve read index, outdoor plus offset clamped to the table
  always_comb begin
    ix_raw = 10'(in_item.outdoor) + 10'(CURVE_OFFSET);
    if (ix_raw < 10'sd0) begin
      rd_idx = '0;
    end else if (ix_raw > IDX_MAX) begin
      rd_idx = AW'(IDX_MAX);
    end else begin
      rd_idx = AW'(ix_raw);
    end
  end

  // curve writes beyond the table depth are dropped
  assign curve_we = s_fire && (in_item.func == dmi_pkg::FUNC_CURVE_WRITE)
                    && (32'(in_cidx) < CURVE_DEPTH);

  dmi_ram #(
    .WIDTH (8),
    .DEPTH (CURVE_DEPTH)
  ) u_curve_ram (
    .clk_i   (clk_i),
    .we_i    (curve_we),
    .waddr_i (AW'(in_cidx)),
    .wdata_i (in_cval),
    .re_i    (s_fire && (in_item.func == dmi_pkg::FUNC_EVALUATE)),
    .raddr_i (rd_idx),
    .rdata_o (curve_rdata)
  );

  // stage one word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_fire) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_q <= in_item;
    end
  end

  // minute accumulate with saturation and sign clearing
  always_comb begin
    minute_hit = {6'b0, s1_q.secs} >= boundary_q;
    setpoint   = remote_en_q ? remote_sp_q : $signed(curve_rdata);
    diff       = 9'(s1_q.flow) - 9'(setpoint);
    acc_ext    = 33'(acc_q);
    diff_ext   = 33'(diff);
    sum        = acc_ext + diff_ext;
    if (sum[32] != sum[31]) begin
      sum_sat = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sum_sat = sum[31:0];
    end
    if (s1_q.dir && sum_sat < 32'sd0) begin
      acc_clamped = '0;
    end else if (!s1_q.dir && sum_sat > 32'sd0) begin
      acc_clamped = '0;
    end else begin
      acc_clamped = sum_sat;
    end
    acc_a      = minute_hit ? acc_clamped : acc_q;
    boundary_a = boundary_q;
    if (minute_hit && boundary_q < dmi_pkg::BOUNDARY_MAX) begin
      boundary_a = boundary_q + dmi_pkg::BOUNDARY_FIRST;
    end
  end

  // threshold check and trigger
  always_comb begin
    on_ext     = 32'(on_thr_q);
    off_ext    = 32'(off_thr_q);
    outdoor_ok = (int'(s1_q.outdoor) < dmi_pkg::OUTDOOR_HIGH_LIMIT)
                 && (int'(s1_q.outdoor) > dmi_pkg::OUTDOOR_LOW_LIMIT);
    acc_d      = acc_a;
    boundary_d = boundary_a;
    met_d      = 1'b0;
    if (s1_q.func == dmi_pkg::FUNC_CURVE_WRITE) begin
      acc_d      = acc_q;
      boundary_d = boundary_q;
    end else if (!s1_q.dir) begin
      if (acc_a <= off_ext) begin
        boundary_d = dmi_pkg::BOUNDARY_FIRST;
        if (outdoor_ok) begin
          acc_d = '0;
          met_d = 1'b1;
        end
      end
    end else if (acc_a >= on_ext) begin
      boundary_d = dmi_pkg::BOUNDARY_FIRST;
      acc_d      = '0;
      met_d      = 1'b1;
    end
  end

  // integrator state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      boundary_q <= dmi_pkg::BOUNDARY_FIRST;
    end else if (advance) begin
      acc_q      <= acc_d;
      boundary_q <= boundary_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_met_q <= met_d;
      out_dm_q  <= acc_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_dm_q, out_met_q};

  // checks
  `DMI_ASSERT_IMPLY(a_met_clears_acc, clk_i, rst_ni,
    m_axis_tvalid_o && out_met_q, out_dm_q == 32'sd0, "trigger with nonzero accumulator")
  `DMI_ASSERT_IMPLY(a_boundary_floor, clk_i, rst_ni,
    1'b1, boundary_q >= dmi_pkg::BOUNDARY_FIRST, "minute boundary below one minute")
  `DMI_ASSERT_NEXT(a_trigger_restarts, clk_i, rst_ni,
    advance && met_d, boundary_q == dmi_pkg::BOUNDARY_FIRST, "trigger kept minute index")
  `DMI_ASSERT_NEXT(a_write_keeps_acc, clk_i, rst_ni,
    advance && (s1_q.func == dmi_pkg::FUNC_CURVE_WRITE), $stable(acc_q),
    "curve write changed accumulator")

endmodule

`default_nettype wire

/* sim/degree_minute_integrator_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// degree_minute_integrator_top_tb
// self-checking bench for the degree-minute integrator
// ----------------------------------------------------------------------------
// Runs a short table of curve writes and evaluate words that cover minute
// boundaries, sign clearing, both trigger directions and the outdoor window
// of the off direction. Random regulation runs follow under several
// register settings, threshold extremes among them. Every result word is
// compared with a hand-written value or a cycle-free model kept in the bench.
// The sender pauses in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------

module degree_minute_integrator_top_tb;

  localparam int CURVE_DEPTH  = 64;
  localparam int CURVE_OFFSET = 20;
  localparam int PHASE_COUNT  = 6;
  localparam int PHASE_WORDS  = 290;
  localparam int CYCLE_LIMIT  = 400000;
  localparam longint ACC_MAX  = (longint'(1) << 31) - 1;
  localparam longint ACC_MIN  = -(longint'(1) << 31);

  // one input word, split into its fields
  typedef struct {
    logic              func;
    logic [19:0]       secs;
    logic signed [7:0] flow;
    logic signed [6:0] outdoor;
    logic              dir;
    logic [5:0]        cidx;
    logic signed [7:0] cval;
  } sample_t;

  // one result word
  typedef struct {
    logic               met;
    logic signed [31:0] dm;
  } result_t;

  // directed row with an optional hand-written result
  typedef struct {
    sample_t            w;
    bit                 typed;
    logic               met;
    logic signed [31:0] dm;
  } row_t;

  // one register setting
  typedef struct {
    logic               en;
    logic signed [7:0]  sp;
    logic signed [15:0] on_t;
    logic signed [15:0] off_t;
  } setting_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [dmi_pkg::CFG_ADDR_W-1:0] cfg_addr_i;
  logic [dmi_pkg::CFG_DATA_W-1:0] cfg_wdata_i;
  logic                           s_axis_tvalid_i;
  logic                           s_axis_tready_o;
  // elapsed_seconds[19:0], flow_temp[27:20], outdoor_temp[34:28],
  // direction[35], curve_index[41:36], curve_value[49:42], zero[55:50]
  logic [55:0]                    s_axis_tdata_i;
  // func[0]
  logic                           s_axis_tuser_i;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i;
  // condition_met[0], degree_minutes[32:1], zero[39:33]
  logic [39:0]                    m_axis_tdata_o;

  degree_minute_integrator_top #(
    .CURVE_DEPTH  (CURVE_DEPTH),
    .CURVE_OFFSET (CURVE_OFFSET)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // integrator state mirrored in the bench
  logic signed [31:0] dm_acc     = '0;
  int unsigned        minute_idx = 1;
  logic signed [7:0]  curve_mem [CURVE_DEPTH];
  bit                 curve_valid [CURVE_DEPTH];
  logic               remote_en  = 1'b0;
  logic signed [7:0]  remote_sp  = dmi_pkg::REMOTE_SETPOINT_RST;
  logic signed [15:0] on_thr     = dmi_pkg::ON_THRESHOLD_RST;
  logic signed [15:0] off_thr    = dmi_pkg::OFF_THRESHOLD_RST;

  result_t     pending_results [$];
  result_t     oldest_result;
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          burst_left     = 0;
  int          stall_left     = 0;
  int          stall_mode     = 0;
  logic [19:0] run_secs       = '0;
  logic        run_dir        = 1'b1;

  // directed words: curve fill, boundaries, clearing, both directions
  row_t directed_rows [0:17] = '{
    '{'{dmi_pkg::FUNC_CURVE_WRITE, 20'hFFFFF, 8'sd127, 7'sd63, 1'b1, 6'd0, -8'sd64},
      1'b1, 1'b0, 32'sd0},
    '{'{dmi_pkg::FUNC_CURVE_WRITE, 20'd0, -8'sd64, -7'sd64, 1'b0, 6'd63, 8'sd127},
      1'b1, 1'b0, 32'sd0},
    '{'{dmi_pkg::FUNC_CURVE_WRITE, 20'd0, 8'sd0, 7'sd0, 1'b0, 6'd20, 8'sd40},
      1'b1, 1'b0, 32'sd0},
    '{'{dmi_pkg::FUNC_CURVE_WRITE, 20'd5, 8'sd3, 7'sd1, 1'b1, 6'd36, 8'sd30},
      1'b0, 1'b0, 32'sd0},
    '{'{dmi_pkg::FUNC_CURVE_WRITE, 20'd0, 8'sd0, 7'sd0, 1'b0, 6'd1, -8'sd10},
      1'b0, 1'b0, 32'sd0},
    '{'{dmi_pkg::FUNC_CURVE_WRITE, 20'd0, 8'sd0, 7'sd0, 1'b0, 6'd37, 8'sd25},
      1'b0, 1'b0, 32'sd0},
    // no minute passed yet, nothing to trigger
    '{'{dmi_pkg::FUNC_EVALUATE, 20'd0, 8'sd50, 7'sd0, 1'b1, 6'd0, 8'sd0},
      1'b1, 1'b0, 32'sd0},
    // large on-direction step fires and clears
    '{'{dmi_pkg::FUNC_EVALUATE, 20'd60, 8'sd127, 7'sd0, 1'b1, 6'd0, 8'sd0},
      1'b1, 1'b1, 32'sd0},
    '{'{dmi_pkg::FUNC_EVALUATE, 20'd60, 8'sd45, 7'sd0, 1'b1, 6'd0, 8'sd0},
      1'b0, 1'b0, 32'sd0},
    // one second short of the next minute
    '{'{dmi_pkg::FUNC_EVALUATE, 20'd119, 8'sd45, 7'sd0, 1'b1, 6'd0, 8'sd0},
      1'b0, 1'b0, 32'sd0},
    // negative residue in on direction is cleared
    '{'{dmi_pkg::FUNC_EVALUATE, 20'd120, 8'sd30, 7'sd0, 1'b1, 6'd0, 8'sd0},
      1'b0, 1'b0, 32'sd0},
    // off direction inside the outdoor window
    '{'{dmi_pkg::FUNC_EVALUATE, 20'd180, 8'sd30, 7'sd16, 1'b0, 6'd0, 8'sd0},
      1'b0, 1'b0, 32'sd0},
    '{'{dmi_pkg::FUNC_EVALUATE, 20'd60, 8'sd20, -7'sd19, 1'b0, 6'd0, 8'sd0},
      1'b0, 1'b0, 32'sd0},
    // off direction at the window edges, value kept
    '{'{dmi_pkg::FUNC_EVALUATE, 20'd60, 8'sd10, 7'sd17, 1'b0, 6'd0, 8'sd0},
      1'b0, 1'b0, 32'sd0},
    '{'{dmi_pkg::FUNC_EVALUATE, 20'd60, -8'sd64, -7'sd20, 1'b0, 6'd0, 8'sd0},
      1'b0, 1'b0, 32'sd0},
    // extremes of temperature and seconds, curve index saturates
    '{'{dmi_pkg::FUNC_EVALUATE, 20'hFFFFF, -8'sd64, 7'sd63, 1'b0, 6'd0, 8'sd0},
      1'b0, 1'b0, 32'sd0},
    '{'{dmi_pkg::FUNC_EVALUATE, 20'hFFFFF, 8'sd127, -7'sd64, 1'b1, 6'd63, 8'sd127},
      1'b0, 1'b0, 32'sd0},
    '{'{dmi_pkg::FUNC_CURVE_WRITE, 20'd0, 8'sd0, 7'sd0, 1'b0, 6'd42, 8'sd0},
      1'b0, 1'b0, 32'sd0}
  };

  // register settings per random phase, the last one is drawn at run time
  setting_t phase_settings [PHASE_COUNT] = '{
    '{1'b0, 8'sd50, 16'sd15, 16'sd0},
    '{1'b1, -8'sd64, 16'sd32767, -16'sd32768},
    '{1'b1, 8'sd127, -16'sd32768, 16'sd32767},
    '{1'b0, 8'sd0, 16'sd100, -16'sd100},
    '{1'b0, 8'sd10, 16'sd1, -16'sd1},
    '{1'b1, 8'sd20, 16'sd40, -16'sd40}
  };

  // heating-curve entry picked by outdoor temperature
  function automatic int curve_slot(input logic signed [6:0] outdoor);
    int slot;
    slot = int'(outdoor) + CURVE_OFFSET;
    if (slot < 0) slot = 0;
    if (slot > CURVE_DEPTH - 1) slot = CURVE_DEPTH - 1;
    return slot;
  endfunction

  // advance the integrator by one word and return its result
  function automatic result_t integrate_step(input sample_t w);
    result_t           r;
    logic signed [7:0] setpoint;
    longint            sum;
    r.met = 1'b0;
    if (w.func == dmi_pkg::FUNC_CURVE_WRITE) begin
      curve_mem[w.cidx]   = w.cval;
      curve_valid[w.cidx] = 1'b1;
    end else begin
      // minute boundary passed: accumulate flow minus setpoint
      if (longint'(w.secs) >=
          longint'(dmi_pkg::SECONDS_PER_MINUTE) * longint'(minute_idx)) begin
        setpoint = remote_en ? remote_sp : curve_mem[curve_slot(w.outdoor)];
        if (minute_idx < dmi_pkg::MINUTE_MAX) minute_idx++;
        sum = longint'(dm_acc) + longint'(w.flow) - longint'(setpoint);
        if (sum > ACC_MAX) dm_acc = ACC_MAX[31:0];
        else if (sum < ACC_MIN) dm_acc = ACC_MIN[31:0];
        else dm_acc = sum[31:0];
        if (w.dir && dm_acc < 0) dm_acc = '0;
        else if (!w.dir && dm_acc > 0) dm_acc = '0;
      end
      // threshold test on every evaluate
      if (!w.dir) begin
        if (dm_acc <= off_thr) begin
          minute_idx = 1;
          if (int'(w.outdoor) < dmi_pkg::OUTDOOR_HIGH_LIMIT &&
              int'(w.outdoor) > dmi_pkg::OUTDOOR_LOW_LIMIT) begin
            dm_acc = '0;
            r.met  = 1'b1;
          end
        end
      end else if (dm_acc >= on_thr) begin
        minute_idx = 1;
        dm_acc     = '0;
        r.met      = 1'b1;
      end
    end
    r.dm = dm_acc;
    return r;
  endfunction

  // random word: mostly a running regulation sequence, some noise
  function automatic sample_t draw_word();
    sample_t w;
    int      shape;
    int      base;
    int      f;
    shape     = $urandom_range(0, 99);
    w.func    = dmi_pkg::FUNC_EVALUATE;
    w.cidx    = 6'($urandom);
    w.cval    = 8'($urandom_range(0, 191) - 64);
    w.secs    = 20'($urandom);
    w.flow    = 8'($urandom_range(0, 191) - 64);
    w.outdoor = 7'($urandom);
    w.dir     = 1'($urandom);
    if (shape < 8) begin
      w.func = dmi_pkg::FUNC_CURVE_WRITE;
    end else if (shape >= 14) begin
      if ($urandom_range(0, 30) == 0) run_secs = 20'($urandom_range(0, 59));
      else if (int'(run_secs) + 75 > 20'hFFFFF) run_secs = 20'hFFFFF;
      else run_secs = run_secs + 20'($urandom_range(0, 75));
      if ($urandom_range(0, 40) == 0) run_dir = !run_dir;
      w.secs    = run_secs;
      w.dir     = run_dir;
      w.outdoor = 7'($urandom_range(0, 50) - 25);
      if (remote_en) base = int'(remote_sp);
      else if (curve_valid[curve_slot(w.outdoor)]) base = int'(curve_mem[curve_slot(w.outdoor)]);
      else base = 40;
      f = base + $urandom_range(0, 24) - 12;
      if (f < -64) f = -64;
      if (f > 127) f = 127;
      w.flow = 8'(f);
    end
    // never evaluate against a curve entry that holds nothing yet
    if (w.func == dmi_pkg::FUNC_EVALUATE && !curve_valid[curve_slot(w.outdoor)]) begin
      w.func = dmi_pkg::FUNC_CURVE_WRITE;
      w.cidx = 6'(curve_slot(w.outdoor));
    end
    return w;
  endfunction

  // offer one word until accepted, then queue its expected result
  task automatic send_word(input sample_t w, input bit typed, input logic met,
                           input logic signed [31:0] dm);
    result_t r;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = w.func;
    s_axis_tdata_i  = {6'd0, w.cval, w.cidx, w.dir, w.outdoor, w.flow, w.secs};
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = integrate_step(w);
    if (typed) begin
      r.met = met;
      r.dm  = dm;
    end
    pending_results.push_back(r);
  endtask

  // bursts of words with random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 24);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // hold off the sender until every result word is back
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [dmi_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [dmi_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      dmi_pkg::REG_REMOTE_ENABLE:   remote_en = value[0];
      dmi_pkg::REG_REMOTE_SETPOINT: remote_sp = value[7:0];
      dmi_pkg::REG_ON_THRESHOLD:    on_thr    = value;
      dmi_pkg::REG_OFF_THRESHOLD:   off_thr   = value;
      default: ;
    endcase
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall pattern: always ready, random, or periodic
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
        0:       m_axis_tready_i = 1'b1;
        1:       m_axis_tready_i = ($urandom_range(0, 3) != 0);
        default: m_axis_tready_i = ((stall_left % 5) < 2);
      endcase
    end
  end

  // result word check against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation waiting: %h", m_axis_tdata_o);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (m_axis_tdata_o[0] !== oldest_result.met) begin
          $error("condition_met mismatch: expected %0d, actual %0d",
                 oldest_result.met, m_axis_tdata_o[0]);
          mismatch_count++;
        end
        if (m_axis_tdata_o[32:1] !== oldest_result.dm) begin
          $error("degree_minutes mismatch: expected %0d, actual %0d",
                 oldest_result.dm, $signed(m_axis_tdata_o[32:1]));
          mismatch_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int       i;
    int       p;
    setting_t s;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = '0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = dmi_pkg::FUNC_EVALUATE;
    for (i = 0; i < CURVE_DEPTH; i++) begin
      curve_mem[i]   = '0;
      curve_valid[i] = 1'b0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table under reset settings
    for (i = 0; i < 18; i++) begin
      send_word(directed_rows[i].w, directed_rows[i].typed,
                directed_rows[i].met, directed_rows[i].dm);
      pace_sender();
    end

    // random phases, registers rewritten while idle
    for (p = 0; p < PHASE_COUNT; p++) begin
      s = phase_settings[p];
      if (p == PHASE_COUNT - 1) begin
        s.en    = 1'($urandom);
        s.sp    = 8'($urandom_range(0, 191) - 64);
        s.on_t  = 16'($urandom_range(0, 400) - 50);
        s.off_t = 16'($urandom_range(0, 400) - 350);
      end
      wait_idle();
      write_reg(dmi_pkg::REG_REMOTE_ENABLE, 16'(s.en));
      write_reg(dmi_pkg::REG_REMOTE_SETPOINT, 16'(s.sp));
      write_reg(dmi_pkg::REG_ON_THRESHOLD, s.on_t);
      write_reg(dmi_pkg::REG_OFF_THRESHOLD, s.off_t);
      for (i = 0; i < PHASE_WORDS; i++) begin
        send_word(draw_word(), 1'b0, 1'b0, '0);
        pace_sender();
      end
    end

    // drain and let the pipeline settle
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
